[rtl/lgs_pkg.sv]
`timescale 1ns / 1ps

package lgs_pkg;

  // Fixed field widths
  localparam int ROW_W        = 32;
  localparam int IDX_W        = 10;
  localparam int COLS_W       = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 80;

  // Defaults for top-level parameters
  localparam int DEF_MAX_COLS = 32;
  localparam int DEF_MAX_ROWS = 1024;

  // Result queue depth: room for two results per item plus one draining
  localparam int FIFO_DEPTH   = 4;

  // Reset value of the column count register
  localparam logic [COLS_W-1:0] GRID_COLS_RESET = COLS_W'(32);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RULE_MODE = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // Rule modes
  localparam logic RULE_CONWAY  = 1'b0;
  localparam logic RULE_BORN_TWO = 1'b1;

  // Column bits one cell shows to its neighbors (already masked)
  typedef struct packed {
    logic up;
    logic mid;
    logic row;
  } col_bits_t;

  // Per-item control broadcast to every cell
  typedef struct packed {
    logic load;
    logic flush;
    logic have_middle;
    logic rule_mode;
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] new_cells;
    logic [ROW_W-1:0] marked_cells;
    logic             frame_end;
  } res_t;

  // Count live cells among eight neighbors
  function automatic logic [3:0] count8(input logic [7:0] nb);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 4'(nb[i]);
    end
    return sum;
  endfunction

  // Apply the selected rule; returns {next_state, mark}
  function automatic logic [1:0] apply_rule(input logic mode, input logic alive,
                                            input logic [3:0] n);
    logic now;
    logic mark;
    if (mode == RULE_BORN_TWO) begin
      now  = (n == 4'd2) ? 1'b1 : alive;
      mark = (n == 4'd2);
    end else begin
      now  = alive ? ((n == 4'd2) || (n == 4'd3)) : (n == 4'd3);
      mark = now ^ alive;
    end
    return {now, mark};
  endfunction

endpackage

[rtl/lgs_cell.sv]
`timescale 1ns / 1ps

module lgs_cell (
  input  logic               clk,
  input  logic               en,
  input  lgs_pkg::cell_ctrl_t ctrl,
  input  logic               row_bit,
  input  lgs_pkg::col_bits_t left,
  input  lgs_pkg::col_bits_t right,
  output lgs_pkg::col_bits_t own,
  output logic               new_a,
  output logic               mark_a,
  output logic               new_b,
  output logic               mark_b
);
  import lgs_pkg::*;

  logic       upper;
  logic       middle;
  logic [3:0] n_a;
  logic [3:0] n_b;
  logic [1:0] rule_a;
  logic [1:0] rule_b;
  logic       hm;

  // Show masked column bits to the neighbors
  assign own.up  = upper & en;
  assign own.mid = middle & en;
  assign own.row = row_bit & en;

  // Result for the middle row: above = upper, below = incoming row
  assign n_a = count8({left.up, own.up, right.up, left.mid, right.mid,
                       left.row, own.row, right.row});
  assign rule_a = apply_rule(ctrl.rule_mode, own.mid, n_a);
  assign new_a  = rule_a[1] & en;
  assign mark_a = rule_a[0] & en;

  // Flush result for the incoming row: above = middle if any, below dead
  assign hm  = ctrl.have_middle;
  assign n_b = count8({left.mid & hm, own.mid & hm, right.mid & hm,
                       left.row, right.row, 3'b000});
  assign rule_b = apply_rule(ctrl.rule_mode, own.row, n_b);
  assign new_b  = rule_b[1] & en;
  assign mark_b = rule_b[0] & en;

  // Advance the stored rows on each item; clear them at frame end
  always_ff @(posedge clk) begin
    if (ctrl.flush) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else if (ctrl.load) begin
      upper  <= ctrl.have_middle ? middle : 1'b0;
      middle <= row_bit;
    end
  end

endmodule

[rtl/lgs_res_fifo.sv]
`timescale 1ns / 1ps

module lgs_res_fifo #(
  parameter int DEPTH = lgs_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr0_en,
  input  lgs_pkg::res_t  wr0,
  input  logic           wr1_en,
  input  lgs_pkg::res_t  wr1,
  input  logic           rd_ready,
  output logic           rd_valid,
  output lgs_pkg::res_t  rd_data,
  output logic           space2
);
  import lgs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_p1;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] rd_ptr_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign rd_valid  = (count != '0);
  assign rd_data   = mem[rd_ptr];
  assign pop       = rd_valid && rd_ready;
  assign space2    = (count <= CW'(DEPTH - 2));
  assign wr_ptr_p1 = inc(wr_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (wr0_en && wr1_en) begin
      wr_ptr_next = inc(wr_ptr_p1);
    end else if (wr0_en) begin
      wr_ptr_next = wr_ptr_p1;
    end
    rd_ptr_next = pop ? inc(rd_ptr) : rd_ptr;
    count_next  = count + CW'(wr0_en) + CW'(wr1_en) - CW'(pop);
  end

  // Hold queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store results in arrival order
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr1_en) begin
      mem[wr_ptr_p1] <= wr1;
    end
  end

endmodule

[rtl/life_grid_generation_step_unit.sv]
`timescale 1ns / 1ps

// One-generation step of a two-state cellular automaton, one grid row per
// input item. A row of 32 identical column cells holds the two previous rows;
// each cell trades its bits with its left and right neighbor and computes its
// next state for all columns in the same cycle, so a new row is taken every
// clock while the result queue has room. Each item after a frame's first
// yields the next generation of the row before it, and a row marked tlast
// also yields its own result against a dead row below, closing the frame.
// Results go through a four-entry queue, so the input side stalls only when
// the output side stalls; a frame of R rows gives R results. Configuration
// writes are accepted every cycle and apply from the next row computed.
module life_grid_generation_step_unit #(
  parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  // Row input: tdata = row_cells[31:0]; tlast = last_row
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lgs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  // Result output: tdata = row_index[9:0], new_cells[41:10],
  // marked_cells[73:42], zero[79:74]; tlast = frame_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lgs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // Configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lgs_pkg::COLS_W-1:0]        cfg_data
);
  import lgs_pkg::*;

  localparam int CNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic              rule_mode;
  logic [COLS_W-1:0] grid_cols;
  logic              have_middle;
  logic [CNT_W-1:0]  row_counter;
  logic [CNT_W-1:0]  row_counter_inc;
  logic [CNT_W-1:0]  flush_counter;

  logic              accept;
  logic              push_a;
  logic              push_b;
  cell_ctrl_t        ctrl;
  logic [ROW_W-1:0]  col_en;
  col_bits_t         own_bits   [ROW_W];
  col_bits_t         left_bits  [ROW_W];
  col_bits_t         right_bits [ROW_W];
  logic [ROW_W-1:0]  new_a;
  logic [ROW_W-1:0]  mark_a;
  logic [ROW_W-1:0]  new_b;
  logic [ROW_W-1:0]  mark_b;
  logic [EXT_W-1:0]  idx_a_ext;
  logic [EXT_W-1:0]  idx_b_ext;
  res_t              res_a;
  res_t              res_b;
  res_t              wr0;
  res_t              out_res;
  logic              space2;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode <= RULE_CONWAY;
      grid_cols <= GRID_COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RULE_MODE: rule_mode <= cfg_data[0];
        REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake and cell control
  assign s_axis_tready = space2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_a        = accept && have_middle;
  assign push_b        = accept && s_axis_tlast;

  assign ctrl.load        = accept;
  assign ctrl.flush       = accept && s_axis_tlast;
  assign ctrl.have_middle = have_middle;
  assign ctrl.rule_mode   = rule_mode;

  // Row of column cells with neighbor links; dead border at both ends
  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    assign col_en[c] = (c < MAX_COLS) && (COLS_W'(c) < grid_cols);

    if (c == 0) begin : g_left_edge
      assign left_bits[c] = '0;
    end else begin : g_left
      assign left_bits[c] = own_bits[c-1];
    end

    if (c == ROW_W - 1) begin : g_right_edge
      assign right_bits[c] = '0;
    end else begin : g_right
      assign right_bits[c] = own_bits[c+1];
    end

    lgs_cell u_cell (
      .clk     (clk),
      .en      (col_en[c]),
      .ctrl    (ctrl),
      .row_bit (s_axis_tdata[c]),
      .left    (left_bits[c]),
      .right   (right_bits[c]),
      .own     (own_bits[c]),
      .new_a   (new_a[c]),
      .mark_a  (mark_a[c]),
      .new_b   (new_b[c]),
      .mark_b  (mark_b[c])
    );
  end

  // Row numbering, wrapping at the row limit
  assign row_counter_inc = (row_counter == CNT_W'(MAX_ROWS - 1)) ? '0
                         : row_counter + CNT_W'(1);
  assign flush_counter   = have_middle ? row_counter_inc : row_counter;
  assign idx_a_ext       = EXT_W'(row_counter);
  assign idx_b_ext       = EXT_W'(flush_counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_middle <= 1'b0;
      row_counter <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        have_middle <= 1'b0;
        row_counter <= '0;
      end else begin
        have_middle <= 1'b1;
        row_counter <= flush_counter;
      end
    end
  end

  // Assemble results; the middle-row result goes ahead of the flush result
  assign res_a.row_index    = idx_a_ext[IDX_W-1:0];
  assign res_a.new_cells    = new_a;
  assign res_a.marked_cells = mark_a;
  assign res_a.frame_end    = 1'b0;

  assign res_b.row_index    = idx_b_ext[IDX_W-1:0];
  assign res_b.new_cells    = new_b;
  assign res_b.marked_cells = mark_b;
  assign res_b.frame_end    = 1'b1;

  assign wr0 = push_a ? res_a : res_b;

  lgs_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr0_en   (push_a || push_b),
    .wr0      (wr0),
    .wr1_en   (push_a && push_b),
    .wr1      (res_b),
    .rd_ready (m_axis_tready),
    .rd_valid (m_axis_tvalid),
    .rd_data  (out_res),
    .space2   (space2)
  );

  // Output packing
  assign m_axis_tdata = {(OUT_TDATA_W - IDX_W - 2 * ROW_W)'(0), out_res.marked_cells,
                         out_res.new_cells, out_res.row_index};
  assign m_axis_tlast = out_res.frame_end;

  // A last row closes the frame
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> !have_middle && (row_counter == '0))
    else $error("frame state not cleared after last row");

  // A row that is not last leaves a stored middle row
  a_middle_held: assert property (@(posedge clk) disable iff (rst)
    accept && !s_axis_tlast |=> have_middle)
    else $error("middle row not held after row item");

  // Any item that produces a result makes a result visible next cycle
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    accept && (have_middle || s_axis_tlast) |=> m_axis_tvalid)
    else $error("result missing after producing item");

endmodule
